### design/wtz_pkg.sv
// ----------------------------------------------------------------------------
// wtz_pkg
// shared widths, codes and controller/datapath interface types for the
// window table with stacking depth and point hit test
// ----------------------------------------------------------------------------
package wtz_pkg;

  localparam int SLOTS_DEF = 32;

  localparam int ACT_W   = 3;
  localparam int ID_W    = 8;
  localparam int COORD_W = 16;
  localparam int DEPTH_W = 8;
  localparam int STYLE_W = 8;
  localparam int STAT_W  = 2;
  localparam int ENT_W   = 5 * COORD_W + STYLE_W;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 112;

  localparam logic [ACT_W-1:0] ACT_CREATE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DESTROY_ID = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DESTROY_OW = 3'd2;
  localparam logic [ACT_W-1:0] ACT_HIT        = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ACTIVATE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_ID = 2'd3;

  localparam logic [2:0] MODE_FREE  = 3'd0;
  localparam logic [2:0] MODE_HIT   = 3'd1;
  localparam logic [2:0] MODE_BEST  = 3'd2;
  localparam logic [2:0] MODE_RAISE = 3'd3;
  localparam logic [2:0] MODE_OWNER = 3'd4;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_SCAN      = 4'd1;
  localparam logic [3:0] OP_RD_WID    = 4'd2;
  localparam logic [3:0] OP_RD_BEST   = 4'd3;
  localparam logic [3:0] OP_RD_TGT    = 4'd4;
  localparam logic [3:0] OP_RD_ACT    = 4'd5;
  localparam logic [3:0] OP_REPORT    = 4'd6;
  localparam logic [3:0] OP_CREATE    = 4'd7;
  localparam logic [3:0] OP_FREE_WID  = 4'd8;
  localparam logic [3:0] OP_TGT_WID   = 4'd9;
  localparam logic [3:0] OP_TGT_BEST  = 4'd10;
  localparam logic [3:0] OP_LOAD_CUR  = 4'd11;
  localparam logic [3:0] OP_RAISE_FIN = 4'd12;
  localparam logic [3:0] OP_ACT_NONE  = 4'd13;
  localparam logic [3:0] OP_EMIT      = 4'd14;

  typedef struct packed {
    logic              ready;
    logic [3:0]        op;
    logic [2:0]        mode;
    logic              set_status;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic             scan_fin;
    logic             stopped;
    logic             found;
    logic             freed;
    logic             id_ok;
    logic             act_is_wid;
    logic             act_valid;
    logic             own_more;
    logic             out_busy;
    logic [ACT_W-1:0] action;
  } sts_t;

endpackage

### design/wtz_ctrl.sv
// ----------------------------------------------------------------------------
// wtz_ctrl
// sequencer that walks each action through reads, scans and updates of the
// window table datapath
// ----------------------------------------------------------------------------
module wtz_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  wtz_pkg::sts_t sts,
  output wtz_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_W_FREE  = 4'd2;
  localparam logic [3:0] S_DI_REP  = 4'd3;
  localparam logic [3:0] S_DI_FREE = 4'd4;
  localparam logic [3:0] S_BEST_GO = 4'd5;
  localparam logic [3:0] S_W_BEST  = 4'd6;
  localparam logic [3:0] S_R_RD    = 4'd7;
  localparam logic [3:0] S_R_CUR   = 4'd8;
  localparam logic [3:0] S_R_GO    = 4'd9;
  localparam logic [3:0] S_W_RAISE = 4'd10;
  localparam logic [3:0] S_AFTER   = 4'd11;
  localparam logic [3:0] S_W_OWN   = 4'd12;
  localparam logic [3:0] S_W_HIT   = 4'd13;
  localparam logic [3:0] S_REP_OK  = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.op         = wtz_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (s_tvalid) state_next = S_DISP;
      end
      S_DISP: begin
        unique case (sts.action)
          wtz_pkg::ACT_CREATE: begin
            cmd.op     = wtz_pkg::OP_SCAN;
            cmd.mode   = wtz_pkg::MODE_FREE;
            state_next = S_W_FREE;
          end
          wtz_pkg::ACT_DESTROY_ID: begin
            if (sts.id_ok) begin
              cmd.op     = wtz_pkg::OP_RD_WID;
              state_next = S_DI_REP;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = wtz_pkg::ST_BAD_ID;
              state_next     = S_FIN;
            end
          end
          wtz_pkg::ACT_DESTROY_OW: begin
            cmd.op     = wtz_pkg::OP_SCAN;
            cmd.mode   = wtz_pkg::MODE_OWNER;
            state_next = S_W_OWN;
          end
          wtz_pkg::ACT_HIT: begin
            cmd.op     = wtz_pkg::OP_SCAN;
            cmd.mode   = wtz_pkg::MODE_HIT;
            state_next = S_W_HIT;
          end
          wtz_pkg::ACT_ACTIVATE: begin
            if (sts.id_ok) begin
              cmd.op     = wtz_pkg::OP_TGT_WID;
              state_next = S_R_RD;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = wtz_pkg::ST_BAD_ID;
              state_next     = S_FIN;
            end
          end
          wtz_pkg::ACT_QUERY: begin
            if (sts.act_valid) begin
              cmd.op     = wtz_pkg::OP_RD_ACT;
              state_next = S_REP_OK;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = wtz_pkg::ST_NONE;
              state_next     = S_FIN;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = wtz_pkg::ST_NONE;
            state_next     = S_FIN;
          end
        endcase
      end
      S_W_FREE: begin
        if (sts.scan_fin) begin
          cmd.set_status = 1'b1;
          if (sts.found) begin
            cmd.op     = wtz_pkg::OP_CREATE;
            cmd.status = wtz_pkg::ST_OK;
          end else begin
            cmd.status = wtz_pkg::ST_FULL;
          end
          state_next = S_FIN;
        end
      end
      S_DI_REP: begin
        cmd.op         = wtz_pkg::OP_REPORT;
        cmd.set_status = 1'b1;
        cmd.status     = wtz_pkg::ST_OK;
        state_next     = S_DI_FREE;
      end
      S_DI_FREE: begin
        cmd.op     = wtz_pkg::OP_FREE_WID;
        state_next = sts.act_is_wid ? S_BEST_GO : S_FIN;
      end
      S_BEST_GO: begin
        cmd.op     = wtz_pkg::OP_SCAN;
        cmd.mode   = wtz_pkg::MODE_BEST;
        state_next = S_W_BEST;
      end
      S_W_BEST: begin
        if (sts.scan_fin) begin
          if (sts.found) begin
            cmd.op     = wtz_pkg::OP_TGT_BEST;
            state_next = S_R_RD;
          end else begin
            cmd.op     = wtz_pkg::OP_ACT_NONE;
            state_next = S_AFTER;
          end
        end
      end
      S_R_RD: begin
        cmd.op     = wtz_pkg::OP_RD_TGT;
        state_next = S_R_CUR;
      end
      S_R_CUR: begin
        cmd.op     = wtz_pkg::OP_LOAD_CUR;
        state_next = S_R_GO;
      end
      S_R_GO: begin
        cmd.op     = wtz_pkg::OP_SCAN;
        cmd.mode   = wtz_pkg::MODE_RAISE;
        state_next = S_W_RAISE;
      end
      S_W_RAISE: begin
        if (sts.scan_fin) begin
          cmd.op     = wtz_pkg::OP_RAISE_FIN;
          state_next = S_AFTER;
        end
      end
      S_AFTER: begin
        priority if (sts.action == wtz_pkg::ACT_ACTIVATE) begin
          cmd.op     = wtz_pkg::OP_RD_TGT;
          state_next = S_REP_OK;
        end else if (sts.action == wtz_pkg::ACT_DESTROY_OW) begin
          if (sts.own_more) begin
            cmd.op     = wtz_pkg::OP_SCAN;
            cmd.mode   = wtz_pkg::MODE_OWNER;
            state_next = S_W_OWN;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = sts.freed ? wtz_pkg::ST_OK : wtz_pkg::ST_NONE;
            state_next     = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_W_OWN: begin
        if (sts.scan_fin) begin
          if (sts.stopped) begin
            state_next = S_BEST_GO;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = sts.freed ? wtz_pkg::ST_OK : wtz_pkg::ST_NONE;
            state_next     = S_FIN;
          end
        end
      end
      S_W_HIT: begin
        if (sts.scan_fin) begin
          if (sts.found) begin
            cmd.op     = wtz_pkg::OP_RD_BEST;
            state_next = S_REP_OK;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = wtz_pkg::ST_NONE;
            state_next     = S_FIN;
          end
        end
      end
      S_REP_OK: begin
        cmd.op         = wtz_pkg::OP_REPORT;
        cmd.set_status = 1'b1;
        cmd.status     = wtz_pkg::ST_OK;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op     = wtz_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/wtz_datapath.sv
// ----------------------------------------------------------------------------
// wtz_datapath
// window slot memories, used bits, active slot, slot scan engine and the
// result register
// ----------------------------------------------------------------------------
module wtz_datapath #(
  parameter int SLOTS = wtz_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic [wtz_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wtz_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  input  logic [wtz_pkg::STYLE_W-1:0]         cfg_data,
  input  wtz_pkg::cmd_t                       cmd,
  output wtz_pkg::sts_t                       sts
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = wtz_pkg::COORD_W;
  localparam logic [IW-1:0]            LAST     = IW'(SLOTS - 1);
  localparam logic [wtz_pkg::ID_W-1:0] NONE_ID  = wtz_pkg::ID_W'(SLOTS);
  localparam logic [IW:0]              SLOTS_RS = (IW + 1)'(SLOTS);

  logic [wtz_pkg::ENT_W-1:0]   ent_mem [SLOTS];
  logic [wtz_pkg::DEPTH_W-1:0] dep_mem [SLOTS];
  logic [wtz_pkg::ENT_W-1:0]   ent_rd;
  logic [wtz_pkg::DEPTH_W-1:0] dep_rd;
  logic [IW-1:0]               rd_addr;
  logic                        dep_we;
  logic [IW-1:0]               dep_wa;
  logic [wtz_pkg::DEPTH_W-1:0] dep_wd;

  logic [SLOTS-1:0]            used;
  logic [wtz_pkg::ID_W-1:0]    active;
  logic [wtz_pkg::STYLE_W-1:0] popup;

  logic [wtz_pkg::ACT_W-1:0]   action;
  logic [wtz_pkg::ID_W-1:0]    wid;
  logic [CW-1:0]               px, py, sw, sh, own;
  logic [wtz_pkg::STYLE_W-1:0] sty;
  logic [wtz_pkg::ID_W-1:0]    prev;

  logic                        scanning, pvalid, found, freed, scan_fin, stopped;
  logic [2:0]                  mode;
  logic [IW-1:0]               cnt, pidx, best, tgt, rep;
  logic [IW:0]                 resume;
  logic [wtz_pkg::DEPTH_W-1:0] bestd, cur, top;

  logic [wtz_pkg::STAT_W-1:0]  status;
  logic [wtz_pkg::ID_W-1:0]    res_id;
  logic [CW-1:0]               res_x, res_y, res_w, res_h, res_own;
  logic [wtz_pkg::DEPTH_W-1:0] res_dep;

  logic [wtz_pkg::STAT_W-1:0]  o_status;
  logic [wtz_pkg::ID_W-1:0]    o_id, o_prev;
  logic [CW-1:0]               o_x, o_y, o_w, o_h, o_own;
  logic [wtz_pkg::DEPTH_W-1:0] o_dep;
  logic                        o_focus;

  logic [CW-1:0]               e_x, e_y, e_w, e_h, e_own;
  logic [wtz_pkg::STYLE_W-1:0] e_sty;
  logic                        u, better, contain;
  logic                        sel_m, raise_m, own_m, stop_m, done;
  logic                        accept;

  assign accept = s_tvalid & cmd.ready;
  assign {e_sty, e_own, e_h, e_w, e_y, e_x} = ent_rd;

  assign u       = used[pidx];
  assign better  = !found || (dep_rd > bestd);
  assign contain = (px >= e_x) && ({1'b0, px} < ({1'b0, e_x} + {1'b0, e_w})) &&
                   (py >= e_y) && ({1'b0, py} < ({1'b0, e_y} + {1'b0, e_h}));

  always_comb begin
    sel_m = 1'b0;
    unique case (mode)
      wtz_pkg::MODE_FREE: sel_m = !u && !found;
      wtz_pkg::MODE_HIT:  sel_m = u && better && contain;
      wtz_pkg::MODE_BEST: sel_m = u && better;
      default:            sel_m = 1'b0;
    endcase
  end

  assign raise_m = (mode == wtz_pkg::MODE_RAISE) && u && (dep_rd > cur) && (e_sty != popup);
  assign own_m   = (mode == wtz_pkg::MODE_OWNER) && u && (e_own == own);
  assign stop_m  = own_m && (active == wtz_pkg::ID_W'(pidx));
  assign done    = pvalid && ((pidx == LAST) || stop_m);

  always_comb begin
    unique case (cmd.op)
      wtz_pkg::OP_RD_WID:  rd_addr = wid[IW-1:0];
      wtz_pkg::OP_RD_BEST: rd_addr = best;
      wtz_pkg::OP_RD_TGT:  rd_addr = tgt;
      wtz_pkg::OP_RD_ACT:  rd_addr = active[IW-1:0];
      default:             rd_addr = cnt;
    endcase
  end

  always_comb begin
    dep_we = 1'b0;
    dep_wa = best;
    dep_wd = wtz_pkg::DEPTH_W'(best);
    priority if (pvalid && raise_m) begin
      dep_we = 1'b1;
      dep_wa = pidx;
      dep_wd = dep_rd - 1'b1;
    end else if (cmd.op == wtz_pkg::OP_RAISE_FIN) begin
      dep_we = (top != '0);
      dep_wa = tgt;
      dep_wd = top;
    end else if (cmd.op == wtz_pkg::OP_CREATE) begin
      dep_we = 1'b1;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    ent_rd <= ent_mem[rd_addr];
    dep_rd <= dep_mem[rd_addr];
    if (cmd.op == wtz_pkg::OP_CREATE) begin
      ent_mem[best] <= {sty, own, sh, sw, py, px};
    end
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      active   <= NONE_ID;
      popup    <= wtz_pkg::STYLE_W'(1);
      scanning <= 1'b0;
      pvalid   <= 1'b0;
      scan_fin <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) popup <= cfg_data;

      if (accept) begin
        {sty, own, sh, sw, py, px, wid, action} <= s_tdata[wtz_pkg::ACT_W +
            wtz_pkg::ID_W + 5 * CW + wtz_pkg::STYLE_W - 1:0];
        prev    <= active;
        resume  <= '0;
        freed   <= 1'b0;
        res_id  <= NONE_ID;
        res_x   <= '0;
        res_y   <= '0;
        res_w   <= '0;
        res_h   <= '0;
        res_own <= '0;
        res_dep <= '0;
        status  <= wtz_pkg::ST_NONE;
      end

      // scan engine: read issued from cnt, entry processed in the following cycle
      pvalid   <= scanning;
      scan_fin <= done;
      if (scanning) begin
        pidx <= cnt;
        if (cnt == LAST) begin
          scanning <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (pvalid) begin
        if (sel_m) begin
          found <= 1'b1;
          best  <= pidx;
          bestd <= dep_rd;
        end
        if (raise_m && (dep_rd > top)) top <= dep_rd;
        if (own_m) begin
          used[pidx] <= 1'b0;
          freed      <= 1'b1;
        end
        if (done) stopped <= stop_m;
        if (stop_m) begin
          scanning <= 1'b0;
          pvalid   <= 1'b0;
          resume   <= {1'b0, pidx} + 1'b1;
        end
      end

      if (cmd.set_status) status <= cmd.status;

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (cmd.op)
        wtz_pkg::OP_SCAN: begin
          scanning <= 1'b1;
          mode     <= cmd.mode;
          cnt      <= (cmd.mode == wtz_pkg::MODE_OWNER) ? resume[IW-1:0] : '0;
          found    <= 1'b0;
          top      <= '0;
        end
        wtz_pkg::OP_RD_WID, wtz_pkg::OP_RD_BEST, wtz_pkg::OP_RD_TGT,
        wtz_pkg::OP_RD_ACT: rep <= rd_addr;
        wtz_pkg::OP_REPORT: begin
          res_id  <= wtz_pkg::ID_W'(rep);
          res_x   <= e_x;
          res_y   <= e_y;
          res_w   <= e_w;
          res_h   <= e_h;
          res_own <= e_own;
          res_dep <= dep_rd;
        end
        wtz_pkg::OP_CREATE: begin
          used[best] <= 1'b1;
          res_id     <= wtz_pkg::ID_W'(best);
          res_x      <= px;
          res_y      <= py;
          res_w      <= sw;
          res_h      <= sh;
          res_own    <= own;
          res_dep    <= wtz_pkg::DEPTH_W'(best);
        end
        wtz_pkg::OP_FREE_WID:  used[wid[IW-1:0]] <= 1'b0;
        wtz_pkg::OP_TGT_WID:   tgt <= wid[IW-1:0];
        wtz_pkg::OP_TGT_BEST:  tgt <= best;
        wtz_pkg::OP_LOAD_CUR:  cur <= dep_rd;
        wtz_pkg::OP_RAISE_FIN: active <= wtz_pkg::ID_W'(tgt);
        wtz_pkg::OP_ACT_NONE:  active <= NONE_ID;
        wtz_pkg::OP_EMIT: begin
          m_tvalid <= 1'b1;
          o_status <= status;
          o_id     <= res_id;
          o_x      <= res_x;
          o_y      <= res_y;
          o_w      <= res_w;
          o_h      <= res_h;
          o_own    <= res_own;
          o_dep    <= res_dep;
          o_focus  <= (active != prev);
          o_prev   <= prev;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {5'b0, o_prev, o_focus, o_dep, o_own, o_h, o_w, o_y, o_x, o_id, o_status};

  always_comb begin
    sts            = '0;
    sts.scan_fin   = scan_fin;
    sts.stopped    = stopped;
    sts.found      = found;
    sts.freed      = freed;
    sts.id_ok      = (wid < NONE_ID) && used[wid[IW-1:0]];
    sts.act_is_wid = (active == wid);
    sts.act_valid  = (active < NONE_ID);
    sts.own_more   = (resume < SLOTS_RS);
    sts.out_busy   = m_tvalid;
    sts.action     = action;
  end

endmodule

### design/window_table_zorder_hit_test.sv
// ----------------------------------------------------------------------------
// window_table_zorder_hit_test
// window slot table with stacking depth, point hit test and activation
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Create, hit test and destroy
// by owner walk the slot table one slot per clock through the slot memory
// read port. Destroying the active window adds a depth search and a raise
// pass, once for each active window freed by a destroy by owner. Items are
// handled one at a time; the next item is taken while a result waits on
// the output. The popup style register is written through the cfg channel.
// ----------------------------------------------------------------------------
module window_table_zorder_hit_test #(
  parameter int SLOTS = wtz_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // action, window_id, pos_x, pos_y, size_w, size_h, owner_pid, style_code
  input  logic [wtz_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, result_id, result_x, result_y, result_w, result_h, result_owner,
  // result_depth, focus_changed, prev_active
  output logic [wtz_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  // popup_style_code
  input  logic [wtz_pkg::STYLE_W-1:0]     cfg_data
);

  wtz_pkg::cmd_t cmd;
  wtz_pkg::sts_t sts;

  assign s_tready  = cmd.ready;
  assign cfg_ready = 1'b1;

  wtz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  wtz_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/sv/tb_window_table_zorder_hit_test.sv
// ----------------------------------------------------------------------------
// tb_window_table_zorder_hit_test
// Stimulus and checking for the window table with stacking depth and hit test.
// Create, destroy by id and by owner, hit test, activate and query items are
// sent with random gaps while results are taken with random stalls. A local
// copy of the table predicts every result, and each output transaction is
// compared field by field. The popup style is changed between phases.
// ----------------------------------------------------------------------------
class wtz_scoreboard;
  localparam int NS = wtz_pkg::SLOTS_DEF;
  logic [7:0]  popup;
  bit          used[NS];
  logic [15:0] lft[NS], tp[NS], wd[NS], ht[NS], own[NS];
  logic [7:0]  dep[NS], sty[NS];
  int          active;
  logic [111:0] pending[$];
  int          errors;
  int          seen;

  function new();
    popup = 8'd1;
    active = NS;
    errors = 0;
    seen = 0;
    foreach (used[k]) used[k] = 0;
  endfunction

  function int used_count();
    int n;
    n = 0;
    foreach (used[k]) if (used[k]) n++;
    return n;
  endfunction

  function void raise_window(int t);
    int cur;
    int topd;
    cur = int'(dep[t]);
    topd = 0;
    for (int k = 0; k < NS; k++)
      if (used[k] && dep[k] > cur && sty[k] != popup) begin
        if (dep[k] > topd) topd = int'(dep[k]);
        dep[k] = dep[k] - 8'd1;
      end
    if (topd > 0) dep[t] = topd[7:0];
    active = t;
  endfunction

  function void free_window(int id);
    int best;
    used[id] = 0;
    if (active != id) return;
    best = NS;
    for (int k = 0; k < NS; k++)
      if (used[k] && (best == NS || dep[k] > dep[best])) best = k;
    if (best != NS) raise_window(best);
    else active = NS;
  endfunction

  function logic [111:0] pack_window(logic [1:0] st, int id, logic fc, int prv);
    logic [111:0] r;
    r = '0;
    r[1:0] = st;
    r[9:2] = id[7:0];
    if (id < NS) begin
      r[25:10] = lft[id];
      r[41:26] = tp[id];
      r[57:42] = wd[id];
      r[73:58] = ht[id];
      r[89:74] = own[id];
      r[97:90] = dep[id];
    end
    r[98] = fc;
    r[106:99] = prv[7:0];
    return r;
  endfunction

  // note an accepted input transaction
  function void note_item(logic [103:0] d);
    logic [2:0] act;
    int wid, px, py, prv, rid;
    logic [1:0] st;
    logic [111:0] r;
    act = d[2:0];
    wid = int'(d[10:3]);
    px = int'(d[26:11]);
    py = int'(d[42:27]);
    prv = active;
    st = wtz_pkg::ST_NONE;
    rid = NS;
    r = '0;
    case (act)
      wtz_pkg::ACT_CREATE: begin
        st = wtz_pkg::ST_FULL;
        for (int k = 0; k < NS; k++)
          if (!used[k]) begin
            used[k] = 1;
            lft[k] = d[26:11];
            tp[k] = d[42:27];
            wd[k] = d[58:43];
            ht[k] = d[74:59];
            own[k] = d[90:75];
            sty[k] = d[98:91];
            dep[k] = k[7:0];
            rid = k;
            st = wtz_pkg::ST_OK;
            break;
          end
      end
      wtz_pkg::ACT_DESTROY_ID: begin
        if (wid >= NS || !used[wid]) st = wtz_pkg::ST_BAD_ID;
        else begin
          r = pack_window(wtz_pkg::ST_OK, wid, 1'b0, 0);
          free_window(wid);
          st = wtz_pkg::ST_OK;
        end
      end
      wtz_pkg::ACT_DESTROY_OW: begin
        for (int k = 0; k < NS; k++)
          if (used[k] && own[k] == d[90:75]) begin
            free_window(k);
            st = wtz_pkg::ST_OK;
          end
      end
      wtz_pkg::ACT_HIT: begin
        for (int k = 0; k < NS; k++)
          if (used[k] && (rid == NS || dep[k] > dep[rid]) &&
              px >= lft[k] && px < int'(lft[k]) + int'(wd[k]) &&
              py >= tp[k] && py < int'(tp[k]) + int'(ht[k]))
            rid = k;
        if (rid != NS) st = wtz_pkg::ST_OK;
      end
      wtz_pkg::ACT_ACTIVATE: begin
        if (wid >= NS || !used[wid]) st = wtz_pkg::ST_BAD_ID;
        else begin
          raise_window(wid);
          rid = wid;
          st = wtz_pkg::ST_OK;
        end
      end
      wtz_pkg::ACT_QUERY: begin
        if (active < NS) begin
          rid = active;
          st = wtz_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    if (act == wtz_pkg::ACT_DESTROY_ID && st == wtz_pkg::ST_OK) begin
      r[98] = (active != prv);
      r[106:99] = prv[7:0];
    end else
      r = pack_window(st, rid, active != prv, prv);
    pending.push_back(r);
  endfunction

  task report_mismatch(string what, logic [111:0] got, logic [111:0] want);
    errors++;
    $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
  endtask

  // check an output transaction against the oldest expectation
  task check_result(logic [111:0] got);
    logic [111:0] w;
    seen++;
    if (pending.size() == 0) begin
      report_mismatch("unexpected result", got, '0);
      return;
    end
    w = pending.pop_front();
    if (got[1:0] !== w[1:0]) report_mismatch("status", got, w);
    if (got[9:2] !== w[9:2]) report_mismatch("result_id", got, w);
    if (got[25:10] !== w[25:10]) report_mismatch("result_x", got, w);
    if (got[41:26] !== w[41:26]) report_mismatch("result_y", got, w);
    if (got[57:42] !== w[57:42]) report_mismatch("result_w", got, w);
    if (got[73:58] !== w[73:58]) report_mismatch("result_h", got, w);
    if (got[89:74] !== w[89:74]) report_mismatch("result_owner", got, w);
    if (got[97:90] !== w[97:90]) report_mismatch("result_depth", got, w);
    if (got[98] !== w[98]) report_mismatch("focus_changed", got, w);
    if (got[106:99] !== w[106:99]) report_mismatch("prev_active", got, w);
  endtask
endclass

module tb_window_table_zorder_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = wtz_pkg::SLOTS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [wtz_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [wtz_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wtz_pkg::STYLE_W-1:0] cfg_data = '0;

  wtz_scoreboard sb = new();
  int sent = 0;
  bit sink_on = 1'b0;

  window_table_zorder_hit_test u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task send_item(logic [2:0] act, logic [7:0] wid, logic [15:0] px, logic [15:0] py,
                 logic [15:0] sw, logic [15:0] sh, logic [15:0] ow, logic [7:0] st);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, st, ow, sh, sw, py, px, wid, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(s_tdata);
    sent++;
  endtask

  task write_popup(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.popup = v;
    cfg_valid <= 1'b0;
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4 * NS + 40) @(posedge clk);
  endtask

  task random_item(int owners);
    int r;
    logic [7:0] wid;
    logic [15:0] px, py, sw, sh, ow;
    logic [7:0] st;
    r = $urandom_range(0, 99);
    wid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NS - 1));
    px = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
    py = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
    sw = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 160));
    sh = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 160));
    ow = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, owners));
    st = ($urandom_range(0, 2) == 0) ? sb.popup : 8'($urandom);
    if (r < 28 && sb.used_count() < NS - 2)
      send_item(wtz_pkg::ACT_CREATE, wid, px, py, sw, sh, ow, st);
    else if (r < 40) send_item(wtz_pkg::ACT_DESTROY_ID, wid, px, py, sw, sh, ow, st);
    else if (r < 44) send_item(wtz_pkg::ACT_DESTROY_OW, wid, px, py, sw, sh, ow, st);
    else if (r < 70) send_item(wtz_pkg::ACT_HIT, wid, px, py, sw, sh, ow, st);
    else if (r < 88) send_item(wtz_pkg::ACT_ACTIVATE, wid, px, py, sw, sh, ow, st);
    else if (r < 97) send_item(wtz_pkg::ACT_QUERY, wid, px, py, sw, sh, ow, st);
    else send_item(3'($urandom_range(6, 7)), wid, px, py, sw, sh, ow, st);
  endtask

  // output side with random stalls
  always @(posedge clk) begin
    if (sink_on) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 30) m_tready <= ~m_tready;
      else m_tready <= 1'b1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sink_on <= 1'b1;
    @(posedge clk);
    // empty table cases
    send_item(wtz_pkg::ACT_QUERY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_HIT, 8'd0, 16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_DESTROY_ID, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_ACTIVATE, 8'hff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_DESTROY_OW, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd7, 8'd0);
    send_item(3'd6, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(3'd7, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    // extremes, popup and zero size windows
    send_item(wtz_pkg::ACT_CREATE, 8'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
              8'hff);
    send_item(wtz_pkg::ACT_CREATE, 8'd0, 16'd0, 16'd0, 16'd0, 16'd50, 16'd1, 8'd1);
    send_item(wtz_pkg::ACT_CREATE, 8'd0, 16'd0, 16'd0, 16'd100, 16'd100, 16'd1, 8'd1);
    send_item(wtz_pkg::ACT_CREATE, 8'd0, 16'd10, 16'd10, 16'd20, 16'd20, 16'd2, 8'd0);
    send_item(wtz_pkg::ACT_HIT, 8'd0, 16'hffff, 16'hfffe, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_HIT, 8'd0, 16'd15, 16'd15, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_HIT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_ACTIVATE, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_ACTIVATE, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_QUERY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_DESTROY_ID, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_DESTROY_ID, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_DESTROY_OW, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 8'd0);
    // fill to table full
    for (int k = 0; k < NS; k++)
      send_item(wtz_pkg::ACT_CREATE, 8'd0, 16'(k), 16'(k), 16'd40, 16'd40, 16'd9, 8'(k));
    send_item(wtz_pkg::ACT_ACTIVATE, 8'(NS - 1), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(wtz_pkg::ACT_DESTROY_OW, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd9, 8'd0);
    drain();
    // random phases across popup settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_popup(8'd0);
        1: write_popup(8'hff);
        2: write_popup(8'($urandom));
        default: write_popup(8'd1);
      endcase
      for (int i = 0; i < 170; i++) random_item(ph == 3 ? 2 : 6);
      drain();
    end
    $display("sent %0d items, checked %0d results over 4 popup styles", sent, sb.seen);
    $display("table fill, hit ties, activation raises and active destroys exercised");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### files.f
design/wtz_pkg.sv
design/wtz_ctrl.sv
design/wtz_datapath.sv
design/window_table_zorder_hit_test.sv
tb/sv/tb_window_table_zorder_hit_test.sv
